/* sv/mt19937_seeded_range_draw_unit_macros.svh */
// Assertion macros used by the generator datapath.
// Depends on clock aclk and active-low reset aresetn in the including module.
`ifndef MT19937_SEEDED_RANGE_DRAW_UNIT_MACROS_SVH
`define MT19937_SEEDED_RANGE_DRAW_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MTSRD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define MTSRD_ASSERT_NEXT(lbl, cause, effect, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cause) |=> (effect)) \
        else $error(msg);
`else
`define MTSRD_ASSERT(lbl, prop, msg)
`define MTSRD_ASSERT_NEXT(lbl, cause, effect, msg)
`endif
`endif

/* sv/mtsrd_pkg.sv */
// Shared constants, command/status structs and tempering for the MT19937 draw unit.
// No dependencies.
`default_nettype none
package mtsrd_pkg;
    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 64;

    localparam logic [1:0] FUNC_SEED  = 2'd0;
    localparam logic [1:0] FUNC_RAW   = 2'd1;
    localparam logic [1:0] FUNC_BITS  = 2'd2;
    localparam logic [1:0] FUNC_RANGE = 2'd3;

    localparam logic [31:0] TWIST_MATRIX   = 32'h9908B0DF;
    localparam logic [31:0] HIGH_BIT       = 32'h80000000;
    localparam logic [31:0] LOW_BITS       = 32'h7FFFFFFF;
    localparam logic [31:0] SEED_MULT_FILL = 32'd1812433253;
    localparam logic [31:0] SEED_MULT_KEY  = 32'd1664525;
    localparam logic [31:0] SEED_MULT_MIX  = 32'd1566083941;
    localparam logic [31:0] SEED_INIT      = 32'd19650218;
    localparam logic [31:0] TEMPER_B       = 32'h9D2C5680;
    localparam logic [31:0] TEMPER_C       = 32'hEFC60000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic seed_mul;
        logic seed_wr;
        logic seed_last;
        logic bitlen_step;
        logic draw_start;
        logic word_rd0;
        logic word_rd1;
        logic word_wr;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] in_func;
        logic       in_range_bad;
        logic       in_bits_zero;
        logic [1:0] func;
        logic       seed_end;
        logic       bitlen_done;
        logic       last_word;
        logic       reject;
        logic       out_free;
    } sts_t;

    // Output tempering of one state word.
    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction
endpackage
`default_nettype wire

/* sv/mtsrd_ctrl.sv */
// Controller state machine of the MT19937 draw unit.
// Depends on mtsrd_pkg for the command and status structs.
`default_nettype none
module mtsrd_ctrl (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire mtsrd_pkg::sts_t sts,
    output mtsrd_pkg::cmd_t   cmd
);
    import mtsrd_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SEED_MUL  = 4'd1;
    localparam logic [3:0] S_SEED_WR   = 4'd2;
    localparam logic [3:0] S_SEED_LAST = 4'd3;
    localparam logic [3:0] S_BITLEN    = 4'd4;
    localparam logic [3:0] S_RD0       = 4'd5;
    localparam logic [3:0] S_RD1       = 4'd6;
    localparam logic [3:0] S_WR        = 4'd7;
    localparam logic [3:0] S_CHECK     = 4'd8;
    localparam logic [3:0] S_DONE      = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    // Next state and command decode.
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    case (sts.in_func)
                        FUNC_SEED:  state_next = S_SEED_MUL;
                        FUNC_RANGE: state_next = sts.in_range_bad ? S_DONE : S_BITLEN;
                        default:    state_next = sts.in_bits_zero ? S_DONE : S_RD0;
                    endcase
                end
            end
            S_SEED_MUL: begin
                cmd.seed_mul = 1'b1;
                state_next   = S_SEED_WR;
            end
            S_SEED_WR: begin
                cmd.seed_wr = 1'b1;
                state_next  = sts.seed_end ? S_SEED_LAST : S_SEED_MUL;
            end
            S_SEED_LAST: begin
                cmd.seed_last = 1'b1;
                state_next    = S_DONE;
            end
            S_BITLEN: begin
                if (sts.bitlen_done) begin
                    cmd.draw_start = 1'b1;
                    state_next     = S_RD0;
                end else begin
                    cmd.bitlen_step = 1'b1;
                end
            end
            S_RD0: begin
                cmd.word_rd0 = 1'b1;
                state_next   = S_RD1;
            end
            S_RD1: begin
                cmd.word_rd1 = 1'b1;
                state_next   = S_WR;
            end
            S_WR: begin
                cmd.word_wr = 1'b1;
                if (sts.last_word) begin
                    state_next = (sts.func == FUNC_RANGE) ? S_CHECK : S_DONE;
                end else begin
                    state_next = S_RD0;
                end
            end
            S_CHECK: begin
                if (sts.reject) begin
                    cmd.draw_start = 1'b1;
                    state_next     = S_RD0;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

/* sv/mtsrd_datapath.sv */
// Datapath of the MT19937 draw unit: state memory, seeding, lazy twist, draw and output register.
// Depends on mtsrd_pkg and the assertion macros header.
`default_nettype none
`include "mt19937_seeded_range_draw_unit_macros.svh"
module mtsrd_datapath #(
    parameter int N_WORDS   = mtsrd_pkg::STATE_WORDS,
    parameter int TWIST_OFF = mtsrd_pkg::TWIST_OFFSET
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire mtsrd_pkg::cmd_t                cmd,
    output mtsrd_pkg::sts_t                     sts,
    input  wire logic [1:0]                     s_tuser,
    input  wire logic [mtsrd_pkg::S_TDATA_W-1:0] s_tdata,
    output logic [mtsrd_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                                m_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready
);
    import mtsrd_pkg::*;

    localparam int IDX_W = $clog2(N_WORDS);
    localparam int CNT_W = $clog2(N_WORDS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_WORDS - 1);
    localparam logic [IDX_W-1:0] ONE_IDX  = IDX_W'(1);
    localparam logic [1:0] PH_FILL = 2'd1;
    localparam logic [1:0] PH_KEY  = 2'd2;
    localparam logic [1:0] PH_MIX  = 2'd3;

    // Input field unpacking.
    logic [31:0] in_seed;
    logic [6:0]  in_bits;
    logic [31:0] in_lo;
    logic [31:0] in_hi;
    logic [32:0] in_n;
    logic [6:0]  in_left;
    logic        in_bad;

    assign in_seed = s_tdata[31:0];
    assign in_bits = s_tdata[38:32];
    assign in_lo   = s_tdata[70:39];
    assign in_hi   = s_tdata[102:71];
    assign in_n    = {1'b0, in_hi} - {1'b0, in_lo} + 33'd1;
    assign in_bad  = (in_hi < in_lo);

    always_comb begin
        if (s_tuser == FUNC_RAW) begin
            in_left = 7'd32;
        end else if (in_bits > 7'd64) begin
            in_left = 7'd64;
        end else begin
            in_left = in_bits;
        end
    end

    logic [31:0] mem [N_WORDS];
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;
    logic [31:0] cur_reg;

    logic [1:0]       func_reg;
    logic [31:0]      seed_reg;
    logic [31:0]      lo_reg;
    logic [32:0]      n_reg;
    logic [32:0]      t_reg;
    logic [5:0]       k_reg;
    logic [6:0]       left_reg;
    logic             pos_reg;
    logic [63:0]      acc_reg;
    logic             err_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             seeded_reg;
    logic [IDX_W-1:0] sidx_reg;
    logic [1:0]       phase_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [31:0]      p_reg;
    logic [31:0]      prod_reg;
    logic [63:0]      m_value_reg;
    logic             m_err_reg;
    logic             m_tvalid_reg;

    // Seeding arithmetic.
    logic [31:0] mult_k;
    logic [31:0] p_mix;
    logic [31:0] seed_w;

    assign p_mix = p_reg ^ (p_reg >> 30);

    always_comb begin
        case (phase_reg)
            PH_KEY:  mult_k = SEED_MULT_KEY;
            PH_MIX:  mult_k = SEED_MULT_MIX;
            default: mult_k = SEED_MULT_FILL;
        endcase
        case (phase_reg)
            PH_KEY:  seed_w = (rd_a_reg ^ prod_reg) + seed_reg;
            PH_MIX:  seed_w = (rd_a_reg ^ prod_reg) - 32'(sidx_reg);
            default: seed_w = prod_reg + 32'(sidx_reg);
        endcase
    end

    logic [IDX_W-1:0] sidx_inc;
    assign sidx_inc = (sidx_reg == LAST_IDX) ? ONE_IDX : sidx_reg + ONE_IDX;

    // Twist addresses and the lazily twisted word.
    logic [IDX_W-1:0] nxt_idx;
    logic [IDX_W:0]   far_sum;
    logic [IDX_W-1:0] far_idx;
    logic [31:0]      twist_y;
    logic [31:0]      new_word;
    logic [31:0]      word_out;
    logic [31:0]      word_kept;
    logic [4:0]       drop;

    assign nxt_idx = (idx_reg == LAST_IDX) ? '0 : idx_reg + ONE_IDX;
    assign far_sum = {1'b0, idx_reg} + (IDX_W + 1)'(TWIST_OFF);
    assign far_idx = (far_sum >= (IDX_W + 1)'(N_WORDS)) ?
                     IDX_W'(far_sum - (IDX_W + 1)'(N_WORDS)) : IDX_W'(far_sum);

    assign twist_y  = (cur_reg & HIGH_BIT) | (rd_b_reg & LOW_BITS);
    assign new_word = rd_a_reg ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : 32'd0);
    assign word_out = seeded_reg ? temper(new_word) : 32'd0;
    assign drop      = 5'(6'd32 - {1'b0, left_reg[4:0]});
    assign word_kept = (left_reg < 7'd32) ? (word_out >> drop) : word_out;

    // Memory ports.
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [31:0]      mem_wdata;
    logic             rd_a_en;
    logic [IDX_W-1:0] rd_a_addr;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = new_word;
        if (cmd.seed_wr) begin
            mem_we    = 1'b1;
            mem_waddr = sidx_reg;
            mem_wdata = seed_w;
        end else if (cmd.seed_last) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = HIGH_BIT;
        end else if (cmd.word_wr) begin
            mem_we = seeded_reg;
        end
        rd_a_en = cmd.seed_mul | cmd.word_rd0 | cmd.word_rd1;
        if (cmd.seed_mul) begin
            rd_a_addr = sidx_reg;
        end else if (cmd.word_rd1) begin
            rd_a_addr = far_idx;
        end else begin
            rd_a_addr = idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_a_en) begin
            rd_a_reg <= mem[rd_a_addr];
        end
        if (cmd.word_rd0) begin
            rd_b_reg <= mem[nxt_idx];
        end
    end

    // Item registers, seeding sequence and draw accumulation.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= s_tuser;
            seed_reg  <= in_seed;
            lo_reg    <= in_lo;
            n_reg     <= in_n;
            t_reg     <= in_n;
            k_reg     <= '0;
            left_reg  <= in_left;
            pos_reg   <= 1'b0;
            acc_reg   <= '0;
            err_reg   <= (s_tuser == FUNC_RANGE) && in_bad;
            sidx_reg  <= ONE_IDX;
            phase_reg <= PH_FILL;
            cnt_reg   <= CNT_W'(N_WORDS - 1);
            p_reg     <= SEED_INIT;
        end
        if (cmd.seed_mul) begin
            prod_reg <= mult_k * p_mix;
        end
        if (cmd.seed_wr) begin
            if (cnt_reg == CNT_W'(1)) begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == PH_FILL) begin
                    cnt_reg  <= CNT_W'(N_WORDS);
                    sidx_reg <= ONE_IDX;
                    p_reg    <= SEED_INIT;
                end else begin
                    cnt_reg  <= CNT_W'(N_WORDS - 1);
                    sidx_reg <= sidx_inc;
                    p_reg    <= seed_w;
                end
            end else begin
                cnt_reg  <= cnt_reg - CNT_W'(1);
                sidx_reg <= sidx_inc;
                p_reg    <= seed_w;
            end
        end
        if (cmd.bitlen_step) begin
            t_reg <= t_reg >> 1;
            k_reg <= k_reg + 6'd1;
        end
        if (cmd.draw_start) begin
            left_reg <= {1'b0, k_reg};
            pos_reg  <= 1'b0;
            acc_reg  <= '0;
        end
        if (cmd.word_rd1) begin
            cur_reg <= rd_a_reg;
        end
        if (cmd.word_wr) begin
            left_reg <= (left_reg <= 7'd32) ? 7'd0 : left_reg - 7'd32;
            pos_reg  <= 1'b1;
            if (pos_reg) begin
                acc_reg[63:32] <= word_kept;
            end else begin
                acc_reg[31:0] <= word_kept;
            end
        end
        if (cmd.out_load) begin
            m_value_reg <= ((func_reg == FUNC_RANGE) && !err_reg) ?
                           {32'd0, lo_reg + acc_reg[31:0]} : acc_reg;
            m_err_reg   <= err_reg;
        end
    end

    // Generator position and output handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            seeded_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.seed_last) begin
                idx_reg    <= '0;
                seeded_reg <= 1'b1;
            end else if (cmd.word_wr && seeded_reg) begin
                idx_reg <= nxt_idx;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_err_reg;
    assign m_tvalid = m_tvalid_reg;

    // Status toward the controller.
    always_comb begin
        sts.in_func      = s_tuser;
        sts.in_range_bad = in_bad;
        sts.in_bits_zero = (in_left == 7'd0);
        sts.func         = func_reg;
        sts.seed_end     = (phase_reg == PH_MIX) && (cnt_reg == CNT_W'(1));
        sts.bitlen_done  = (t_reg == '0);
        sts.last_word    = (left_reg <= 7'd32);
        sts.reject       = (acc_reg >= {31'd0, n_reg});
        sts.out_free     = !m_tvalid_reg || m_tready;
    end

    `MTSRD_ASSERT(a_idx_range, (32'(idx_reg) <= 32'(N_WORDS - 1)), "read index out of range")
    `MTSRD_ASSERT(a_err_value, (m_tvalid_reg && m_err_reg) |-> (m_value_reg == '0), "error with value")
    `MTSRD_ASSERT_NEXT(a_seeded_sticky, seeded_reg, seeded_reg, "seeded flag dropped")
endmodule
`default_nettype wire

/* sv/mt19937_seeded_range_draw_unit.sv */
// MT19937 draw unit with reseeding, raw words, top-bit draws and ranged draws.
// Usage: s_ channel carries one request per transfer; s_tuser[1:0] selects the function
// (reseed, raw 32-bit word, top bits, ranged integer). m_ channel returns exactly one
// result per request: the value in m_tdata and a reversed-range flag in m_tuser.
// The unit works on one request at a time. Each generated word takes two reads and a
// write-back on the 624-word state memory, which is twisted one word per generated word.
// The next request is taken after the result is loaded into the output register.
// A ranged draw first measures the span one bit per cycle, then draws one or two words per
// try plus a check step and retries while the sample is out of range.
// A reseed runs 1870 multiply-and-write steps over the state memory.
// After reset the generator is unseeded: raw and bit draws give 0, ranged draws give
// range_low, until the first reseed. A finished result sits in the output register while
// the next request is accepted; if the receiver stalls, the unit holds its next result
// until the output register frees up.
// Depends on mtsrd_pkg, mtsrd_ctrl and mtsrd_datapath.
`default_nettype none
module mt19937_seeded_range_draw_unit #(
    parameter int STATE_WORDS  = mtsrd_pkg::STATE_WORDS,
    parameter int TWIST_OFFSET = mtsrd_pkg::TWIST_OFFSET
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // seed_value[31:0], bit_count[38:32], range_low[70:39], range_high[102:71], zero pad
    input  wire logic [mtsrd_pkg::S_TDATA_W-1:0] s_tdata,
    // func[1:0]
    input  wire logic [1:0]                      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // value[63:0]
    output logic [mtsrd_pkg::M_TDATA_W-1:0]      m_tdata,
    // range_error
    output logic                                 m_tuser
);
    import mtsrd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    mtsrd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mtsrd_datapath #(
        .N_WORDS   (STATE_WORDS),
        .TWIST_OFF (TWIST_OFFSET)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );
endmodule
`default_nettype wire
